// File: rtl/core/kfci_pkg.sv
// Shared constants, codes and types of the keyframe curve interpolator.
`default_nettype none

package kfci_pkg;

    // Key table capacity and the widths that follow from it
    localparam int MAX_KEYS   = 8;
    localparam int IDX_W      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    // Fixed field widths
    localparam int CNT_W      = 4;
    localparam int TIME_W     = 17;
    localparam int CHAN_W     = 16;
    localparam int NUM_CHAN   = 4;
    localparam int COLOR_W    = NUM_CHAN * CHAN_W;
    localparam int COLOR_ENTRY_W = TIME_W + COLOR_W;
    localparam int SIZE_ENTRY_W  = TIME_W + CHAN_W;

    // Restoring divide: one quotient bit per step
    localparam int Q_STEPS    = CHAN_W;
    localparam int DIV_CNT_W  = $clog2(Q_STEPS);

    // Value of an empty curve
    localparam logic [CHAN_W-1:0] ONE_COLOR = 16'hFFFF;
    localparam logic [CHAN_W-1:0] ONE_SIZE  = 16'h0100;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Curve select for key writes
    localparam logic CURVE_COLOR = 1'b0;
    localparam logic CURVE_SIZE  = 1'b1;

    // Register indexes
    localparam logic REG_COLOR_KEY_COUNT = 1'b0;
    localparam logic REG_SIZE_KEY_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    // Per-cycle commands to the interpolation lanes
    typedef struct packed {
        logic prep;
        logic load;
        logic step;
    } lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/kfci_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module kfci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/kfci_lerp_lane.sv
// One interpolation lane: a + trunc((b-a)*dt/den) by multiply and restoring divide.
`default_nettype none

module kfci_lerp_lane (
    input  wire logic                              aclk,
    input  wire kfci_pkg::lane_ctl_t               ctl,
    input  wire logic [kfci_pkg::CHAN_W-1:0]       a,
    input  wire logic [kfci_pkg::CHAN_W-1:0]       b,
    input  wire logic [kfci_pkg::TIME_W-1:0]       dt,
    input  wire logic [kfci_pkg::TIME_W-1:0]       den,
    output logic      [kfci_pkg::CHAN_W-1:0]       result
);

    localparam int PROD_W = kfci_pkg::CHAN_W + kfci_pkg::TIME_W;

    logic [kfci_pkg::CHAN_W-1:0] mag_reg;
    logic                        neg_reg;
    logic [kfci_pkg::TIME_W-1:0] rem_reg;
    logic [kfci_pkg::CHAN_W-1:0] low_reg;

    logic [kfci_pkg::CHAN_W:0]   diff;
    logic [PROD_W-1:0]           prod;
    logic [kfci_pkg::TIME_W:0]   trial;
    logic [kfci_pkg::TIME_W:0]   trial_sub;

    assign diff      = {1'b0, b} - {1'b0, a};
    assign prod      = {{kfci_pkg::TIME_W{1'b0}}, mag_reg}
                     * {{kfci_pkg::CHAN_W{1'b0}}, dt};
    assign trial     = {rem_reg, low_reg[kfci_pkg::CHAN_W-1]};
    assign trial_sub = trial - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (ctl.prep) begin
            neg_reg <= diff[kfci_pkg::CHAN_W];
            mag_reg <= diff[kfci_pkg::CHAN_W] ? kfci_pkg::CHAN_W'(-diff)
                                              : diff[kfci_pkg::CHAN_W-1:0];
        end
        // Quotient fits in CHAN_W bits since dt < den, so the top bits
        // of the product seed the partial remainder directly.
        if (ctl.load) begin
            rem_reg <= prod[PROD_W-1:kfci_pkg::CHAN_W];
            low_reg <= prod[kfci_pkg::CHAN_W-1:0];
        end else if (ctl.step) begin
            if (!trial_sub[kfci_pkg::TIME_W]) begin
                rem_reg <= trial_sub[kfci_pkg::TIME_W-1:0];
                low_reg <= {low_reg[kfci_pkg::CHAN_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[kfci_pkg::TIME_W-1:0];
                low_reg <= {low_reg[kfci_pkg::CHAN_W-2:0], 1'b0};
            end
        end
    end

    // Truncation toward zero: apply the sign to the magnitude quotient
    assign result = neg_reg ? (a - low_reg) : (a + low_reg);

endmodule

`default_nettype wire

// File: rtl/core/keyframe_curve_interpolator_top.sv
// Top level of the keyframe curve interpolator: key tables, scan sequencer, lanes, output.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  s_*      | in        | s_valid / s_ready  | op, curve_select, key_slot, key_time,
//           |           |                    | key_red..key_alpha, key_size, eval_time
//  m_*      | out       | m_valid / m_ready  | out_red, out_green, out_blue, out_alpha,
//           |           |                    | out_size
//  cfg_*    | in        | cfg_wr_en          | cfg_index, cfg_data (key counts)
//
// A key write goes into the table RAM at the transfer edge.
// An evaluate reads key 0 at its transfer, then does one table read per key through the
// RAM read port (the scan stops early once both curves are settled), then one prep, one
// multiply and 16 restoring-divide steps in the lanes, and then loads the output register.
// Reset (aresetn low, synchronous) clears the FSM, the output valid and the key counts;
// the key tables hold whatever was written and need no clearing pass.
// A result held on m_* does not stall s_*: the next item is taken meanwhile, and only
// a finished evaluate waits in its last state until the output register frees up.
`default_nettype none

module keyframe_curve_interpolator_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic                              s_curve_select,
    input  wire logic [2:0]                        s_key_slot,
    input  wire logic [kfci_pkg::TIME_W-1:0]       s_key_time,
    input  wire logic [kfci_pkg::CHAN_W-1:0]       s_key_red,
    input  wire logic [kfci_pkg::CHAN_W-1:0]       s_key_green,
    input  wire logic [kfci_pkg::CHAN_W-1:0]       s_key_blue,
    input  wire logic [kfci_pkg::CHAN_W-1:0]       s_key_alpha,
    input  wire logic [kfci_pkg::CHAN_W-1:0]       s_key_size,
    input  wire logic [kfci_pkg::TIME_W-1:0]       s_eval_time,

    // Result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [kfci_pkg::CHAN_W-1:0]       m_out_red,
    output logic      [kfci_pkg::CHAN_W-1:0]       m_out_green,
    output logic      [kfci_pkg::CHAN_W-1:0]       m_out_blue,
    output logic      [kfci_pkg::CHAN_W-1:0]       m_out_alpha,
    output logic      [kfci_pkg::CHAN_W-1:0]       m_out_size,

    // Configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [kfci_pkg::CNT_W-1:0]        cfg_data
);

    // Scan result of one curve: the segment end points or a constant in a_val
    typedef struct packed {
        logic                           done;
        logic                           lerp;
        logic [kfci_pkg::TIME_W-1:0]    a_time;
        logic [kfci_pkg::TIME_W-1:0]    b_time;
        logic [kfci_pkg::COLOR_W-1:0]   a_val;
        logic [kfci_pkg::COLOR_W-1:0]   b_val;
    } scan_t;

    // One key of the scan: keep the previous key, stop at the first segment
    // holding t, fall back to the first or last key, or to 1.0 when empty.
    function automatic scan_t scan_step(
        scan_t                               cur,
        logic [kfci_pkg::CNT_W-1:0]          n,
        logic [kfci_pkg::IDX_W-1:0]          j,
        logic [kfci_pkg::TIME_W-1:0]         t,
        logic [kfci_pkg::TIME_W-1:0]         d_time,
        logic [kfci_pkg::COLOR_W-1:0]        d_val,
        logic [kfci_pkg::COLOR_W-1:0]        one_val
    );
        scan_t nx;
        nx = cur;
        if (!cur.done) begin
            if (n == '0) begin
                nx.done  = 1'b1;
                nx.lerp  = 1'b0;
                nx.a_val = one_val;
            end else if (j == '0) begin
                if (n == kfci_pkg::CNT_W'(1) || t <= d_time) begin
                    nx.done  = 1'b1;
                    nx.lerp  = 1'b0;
                    nx.a_val = d_val;
                end else begin
                    nx.a_time = d_time;
                    nx.a_val  = d_val;
                end
            end else if (cur.a_time <= t && t < d_time) begin
                nx.done   = 1'b1;
                nx.lerp   = 1'b1;
                nx.b_time = d_time;
                nx.b_val  = d_val;
            end else if (32'(j) + 32'd1 == 32'(n)) begin
                nx.done  = 1'b1;
                nx.lerp  = 1'b0;
                nx.a_val = d_val;
            end else begin
                nx.a_time = d_time;
                nx.a_val  = d_val;
            end
        end
        return nx;
    endfunction

    kfci_pkg::state_t state_reg, state_next;

    // Configuration
    logic [kfci_pkg::CNT_W-1:0] color_cnt_reg;
    logic [kfci_pkg::CNT_W-1:0] size_cnt_reg;
    logic [kfci_pkg::CNT_W-1:0] color_n;
    logic [kfci_pkg::CNT_W-1:0] size_n;

    // Handshake decode
    logic s_xfer;
    logic wr_xfer;
    logic eval_xfer;
    logic slot_ok;

    // Key tables
    logic                                   color_we;
    logic                                   size_we;
    logic                                   rd_en;
    logic [kfci_pkg::IDX_W-1:0]             rd_addr;
    logic [kfci_pkg::IDX_W-1:0]             wr_addr;
    logic [kfci_pkg::COLOR_ENTRY_W-1:0]     color_wdata;
    logic [kfci_pkg::SIZE_ENTRY_W-1:0]      size_wdata;
    logic [kfci_pkg::COLOR_ENTRY_W-1:0]     color_rdata;
    logic [kfci_pkg::SIZE_ENTRY_W-1:0]      size_rdata;

    // Scan state
    logic [kfci_pkg::IDX_W-1:0]             j_reg;
    logic [kfci_pkg::TIME_W-1:0]            t_reg;
    scan_t                                  col_scan_reg, col_scan_next;
    scan_t                                  size_scan_reg, size_scan_next;

    // Lane operands and control
    logic [kfci_pkg::TIME_W-1:0]            col_dt_reg, col_den_reg;
    logic [kfci_pkg::TIME_W-1:0]            size_dt_reg, size_den_reg;
    logic [kfci_pkg::DIV_CNT_W-1:0]         div_cnt_reg;
    kfci_pkg::lane_ctl_t                    lane_ctl;
    logic [kfci_pkg::NUM_CHAN-1:0][kfci_pkg::CHAN_W-1:0] col_res;
    logic [kfci_pkg::CHAN_W-1:0]            size_res;

    // Output register
    logic                                   m_valid_reg;
    logic                                   out_load;
    logic [kfci_pkg::CHAN_W-1:0]            m_out_red_reg;
    logic [kfci_pkg::CHAN_W-1:0]            m_out_green_reg;
    logic [kfci_pkg::CHAN_W-1:0]            m_out_blue_reg;
    logic [kfci_pkg::CHAN_W-1:0]            m_out_alpha_reg;
    logic [kfci_pkg::CHAN_W-1:0]            m_out_size_reg;

    // ------------------------------------------------------------------
    // Input decode and key counts
    // ------------------------------------------------------------------
    assign s_xfer    = s_valid && s_ready;
    assign wr_xfer   = s_xfer && (s_op == kfci_pkg::OP_WRITE);
    assign eval_xfer = s_xfer && (s_op == kfci_pkg::OP_EVAL);
    // Drop writes to slots past the table
    assign slot_ok   = 32'(s_key_slot) < kfci_pkg::MAX_KEYS;

    // Clamp counts above capacity to a full table
    assign color_n = (32'(color_cnt_reg) > kfci_pkg::MAX_KEYS)
                   ? kfci_pkg::CNT_W'(kfci_pkg::MAX_KEYS) : color_cnt_reg;
    assign size_n  = (32'(size_cnt_reg) > kfci_pkg::MAX_KEYS)
                   ? kfci_pkg::CNT_W'(kfci_pkg::MAX_KEYS) : size_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_cnt_reg <= '0;
            size_cnt_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kfci_pkg::REG_COLOR_KEY_COUNT: color_cnt_reg <= cfg_data;
                kfci_pkg::REG_SIZE_KEY_COUNT:  size_cnt_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Key tables: written only in idle, read on the evaluate transfer and while
    // scanning, so a read never races a write to the same slot.
    // ------------------------------------------------------------------
    assign wr_addr     = kfci_pkg::IDX_W'(s_key_slot);
    assign color_we    = wr_xfer && slot_ok && (s_curve_select == kfci_pkg::CURVE_COLOR);
    assign size_we     = wr_xfer && slot_ok && (s_curve_select == kfci_pkg::CURVE_SIZE);
    assign color_wdata = {s_key_time, s_key_alpha, s_key_blue, s_key_green, s_key_red};
    assign size_wdata  = {s_key_time, s_key_size};

    // Read key 0 on the evaluate transfer, then one key ahead of the scan
    assign rd_addr = (state_reg == kfci_pkg::ST_SCAN) ? (j_reg + kfci_pkg::IDX_W'(1)) : '0;

    kfci_ram #(
        .WIDTH (kfci_pkg::COLOR_ENTRY_W),
        .DEPTH (kfci_pkg::MAX_KEYS)
    ) u_color_ram (
        .aclk    (aclk),
        .wr_en   (color_we),
        .wr_addr (wr_addr),
        .wr_data (color_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (color_rdata)
    );

    kfci_ram #(
        .WIDTH (kfci_pkg::SIZE_ENTRY_W),
        .DEPTH (kfci_pkg::MAX_KEYS)
    ) u_size_ram (
        .aclk    (aclk),
        .wr_en   (size_we),
        .wr_addr (wr_addr),
        .wr_data (size_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (size_rdata)
    );

    // ------------------------------------------------------------------
    // Scan: both curves advance one key per cycle on the same index
    // ------------------------------------------------------------------
    always_comb begin
        col_scan_next  = scan_step(col_scan_reg, color_n, j_reg, t_reg,
                                   color_rdata[kfci_pkg::COLOR_ENTRY_W-1:kfci_pkg::COLOR_W],
                                   color_rdata[kfci_pkg::COLOR_W-1:0],
                                   {kfci_pkg::NUM_CHAN{kfci_pkg::ONE_COLOR}});
        size_scan_next = scan_step(size_scan_reg, size_n, j_reg, t_reg,
                                   size_rdata[kfci_pkg::SIZE_ENTRY_W-1:kfci_pkg::CHAN_W],
                                   kfci_pkg::COLOR_W'(size_rdata[kfci_pkg::CHAN_W-1:0]),
                                   kfci_pkg::COLOR_W'(kfci_pkg::ONE_SIZE));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_scan_reg.done  <= 1'b0;
            size_scan_reg.done <= 1'b0;
        end else if (eval_xfer) begin
            col_scan_reg.done  <= 1'b0;
            size_scan_reg.done <= 1'b0;
        end else if (state_reg == kfci_pkg::ST_SCAN) begin
            col_scan_reg  <= col_scan_next;
            size_scan_reg <= size_scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_xfer) begin
            t_reg <= s_eval_time;
            j_reg <= '0;
        end else if (state_reg == kfci_pkg::ST_SCAN) begin
            j_reg <= j_reg + kfci_pkg::IDX_W'(1);
        end
        // Segment offsets for the lanes, taken with the lanes' prep
        if (state_reg == kfci_pkg::ST_PREP) begin
            col_dt_reg   <= t_reg - col_scan_reg.a_time;
            col_den_reg  <= col_scan_reg.b_time - col_scan_reg.a_time;
            size_dt_reg  <= t_reg - size_scan_reg.a_time;
            size_den_reg <= size_scan_reg.b_time - size_scan_reg.a_time;
        end
    end

    // Count divide steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (state_reg == kfci_pkg::ST_DIV) begin
            div_cnt_reg <= div_cnt_reg + kfci_pkg::DIV_CNT_W'(1);
        end else begin
            div_cnt_reg <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Interpolation lanes: four color channels and size
    // ------------------------------------------------------------------
    for (genvar g = 0; g < kfci_pkg::NUM_CHAN; g++) begin : g_col_lane
        kfci_lerp_lane u_lane (
            .aclk   (aclk),
            .ctl    (lane_ctl),
            .a      (col_scan_reg.a_val[g*kfci_pkg::CHAN_W +: kfci_pkg::CHAN_W]),
            .b      (col_scan_reg.b_val[g*kfci_pkg::CHAN_W +: kfci_pkg::CHAN_W]),
            .dt     (col_dt_reg),
            .den    (col_den_reg),
            .result (col_res[g])
        );
    end

    kfci_lerp_lane u_size_lane (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .a      (size_scan_reg.a_val[kfci_pkg::CHAN_W-1:0]),
        .b      (size_scan_reg.b_val[kfci_pkg::CHAN_W-1:0]),
        .dt     (size_dt_reg),
        .den    (size_den_reg),
        .result (size_res)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kfci_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kfci_pkg::ST_IDLE: begin
                if (eval_xfer) begin
                    state_next = kfci_pkg::ST_SCAN;
                end
            end
            kfci_pkg::ST_SCAN: begin
                if (col_scan_next.done && size_scan_next.done) begin
                    state_next = kfci_pkg::ST_PREP;
                end
            end
            kfci_pkg::ST_PREP: state_next = kfci_pkg::ST_LOAD;
            kfci_pkg::ST_LOAD: state_next = kfci_pkg::ST_DIV;
            kfci_pkg::ST_DIV: begin
                if (div_cnt_reg == kfci_pkg::DIV_CNT_W'(kfci_pkg::Q_STEPS - 1)) begin
                    state_next = kfci_pkg::ST_DONE;
                end
            end
            kfci_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = kfci_pkg::ST_IDLE;
                end
            end
            default: state_next = kfci_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        rd_en         = 1'b0;
        lane_ctl      = '0;
        out_load      = 1'b0;
        case (state_reg)
            kfci_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                rd_en   = eval_xfer;
            end
            kfci_pkg::ST_SCAN: rd_en         = 1'b1;
            kfci_pkg::ST_PREP: lane_ctl.prep = 1'b1;
            kfci_pkg::ST_LOAD: lane_ctl.load = 1'b1;
            kfci_pkg::ST_DIV:  lane_ctl.step = 1'b1;
            kfci_pkg::ST_DONE: out_load      = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until its transfer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_red_reg   <= col_scan_reg.lerp ? col_res[0]
                             : col_scan_reg.a_val[0*kfci_pkg::CHAN_W +: kfci_pkg::CHAN_W];
            m_out_green_reg <= col_scan_reg.lerp ? col_res[1]
                             : col_scan_reg.a_val[1*kfci_pkg::CHAN_W +: kfci_pkg::CHAN_W];
            m_out_blue_reg  <= col_scan_reg.lerp ? col_res[2]
                             : col_scan_reg.a_val[2*kfci_pkg::CHAN_W +: kfci_pkg::CHAN_W];
            m_out_alpha_reg <= col_scan_reg.lerp ? col_res[3]
                             : col_scan_reg.a_val[3*kfci_pkg::CHAN_W +: kfci_pkg::CHAN_W];
            m_out_size_reg  <= size_scan_reg.lerp ? size_res
                             : size_scan_reg.a_val[kfci_pkg::CHAN_W-1:0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_out_red_reg;
    assign m_out_green = m_out_green_reg;
    assign m_out_blue  = m_out_blue_reg;
    assign m_out_alpha = m_out_alpha_reg;
    assign m_out_size  = m_out_size_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A finished evaluate must not overwrite a result still waiting
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kfci_pkg::ST_DONE && m_valid_reg && !m_ready)
        |=> (state_reg == kfci_pkg::ST_DONE))
        else $error("evaluate left its final state while the output was occupied");

    // The scan must settle both curves by the last table slot
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kfci_pkg::ST_SCAN && 32'(j_reg) + 32'd1 >= kfci_pkg::MAX_KEYS)
        |-> (state_next == kfci_pkg::ST_PREP))
        else $error("key scan ran past the last slot");

    // An interpolated size lies between its two keys
    a_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kfci_pkg::ST_DONE && size_scan_reg.lerp)
        |-> ((size_res >= size_scan_reg.a_val[kfci_pkg::CHAN_W-1:0]
              && size_res <= size_scan_reg.b_val[kfci_pkg::CHAN_W-1:0])
          || (size_res <= size_scan_reg.a_val[kfci_pkg::CHAN_W-1:0]
              && size_res >= size_scan_reg.b_val[kfci_pkg::CHAN_W-1:0])))
        else $error("size interpolation out of segment range");

    // An interpolated red channel lies between its two keys
    a_red_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kfci_pkg::ST_DONE && col_scan_reg.lerp)
        |-> ((col_res[0] >= col_scan_reg.a_val[kfci_pkg::CHAN_W-1:0]
              && col_res[0] <= col_scan_reg.b_val[kfci_pkg::CHAN_W-1:0])
          || (col_res[0] <= col_scan_reg.a_val[kfci_pkg::CHAN_W-1:0]
              && col_res[0] >= col_scan_reg.b_val[kfci_pkg::CHAN_W-1:0])))
        else $error("red interpolation out of segment range");

endmodule

`default_nettype wire
